FILE: rtl/core/srs_pkg.sv
// Package for the servo recipe sequencer: sizes, codes, per-servo context and result types.
// Has no dependencies; srs_exec and the top level use it.
package srs_pkg;

    localparam int RECIPE_DEPTH = 128;
    localparam int SERVO_COUNT = 2;

    localparam int ADDR_W = $clog2(RECIPE_DEPTH);
    localparam int SERVO_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int LOAD_ADDR_W = 7;
    localparam int WRAP_STEPS = $clog2(127 / RECIPE_DEPTH + 1);

    localparam logic [4:0] RESET_POSITION = 5'd3;
    localparam logic [4:0] MAX_POSITION_RESET = 5'd5;
    localparam logic [7:0] MOVE_UNITS = 8'd5;
    localparam logic [7:0] MANUAL_HOLD = 8'd10;

    typedef enum logic [1:0] {
        KIND_STEP     = 2'd0,
        KIND_OVERRIDE = 2'd1,
        KIND_LOAD     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CMD_PAUSE    = 3'd0,
        CMD_CONTINUE = 3'd1,
        CMD_RIGHT    = 3'd2,
        CMD_LEFT     = 3'd3,
        CMD_NONE     = 3'd4,
        CMD_RESTART  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        OP_END      = 3'd0,
        OP_MOV      = 3'd1,
        OP_WAIT     = 3'd2,
        OP_LOOP     = 3'd4,
        OP_END_LOOP = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_RUNNING = 3'd0,
        MODE_PAUSED  = 3'd1,
        MODE_END     = 3'd2,
        MODE_NESTED  = 3'd3,
        MODE_CMD_ERR = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CFG_PULSE_BASE   = 2'd0,
        CFG_PULSE_STEP   = 2'd1,
        CFG_MAX_POSITION = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] loop_start;
        logic [4:0]        loop_count;
        logic [4:0]        loop_times;
        logic              loop_active;
        logic [4:0]        position;
        mode_t             mode;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        pc:          '0,
        loop_start:  '0,
        loop_count:  5'd0,
        loop_times:  5'd0,
        loop_active: 1'b0,
        position:    RESET_POSITION,
        mode:        MODE_RUNNING
    };

    typedef struct packed {
        logic [15:0] pulse_base;
        logic [10:0] pulse_step;
        logic [4:0]  max_position;
    } cfg_t;

    typedef struct packed {
        logic [16:0] pulse_len;
        logic        pulse_update;
        logic [7:0]  hold_units;
        mode_t       mode;
    } res_t;

    // Reduces a load address into the recipe range with a short restoring subtract chain.
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [LOAD_ADDR_W-1:0] a);
        logic [LOAD_ADDR_W-1:0] v;
        v = a;
        for (int k = WRAP_STEPS - 1; k >= 0; k--)
        begin
            if (int'(v) >= (RECIPE_DEPTH << k))
            begin
                v = v - LOAD_ADDR_W'(RECIPE_DEPTH << k);
            end
        end
        return ADDR_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] i);
        return (i == ADDR_W'(RECIPE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

FILE: rtl/core/srs_channels.sv
// Valid/ready channel interfaces of the servo recipe sequencer: items, results, configuration.
// Depends on nothing; the top level uses the source and sink modports.
interface srs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       servo_id;
    logic [2:0] command;
    logic [6:0] load_addr;
    logic [7:0] load_byte;

    modport source (output valid, kind, servo_id, command, load_addr, load_byte, input ready);
    modport sink (input valid, kind, servo_id, command, load_addr, load_byte, output ready);
endinterface

interface srs_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] pulse_len;
    logic        pulse_update;
    logic [7:0]  hold_units;
    logic [2:0]  mode;

    modport source (output valid, pulse_len, pulse_update, hold_units, mode, input ready);
    modport sink (input valid, pulse_len, pulse_update, hold_units, mode, output ready);
endinterface

interface srs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/srs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies; holds the recipe bytes of the sequencer.
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/srs_exec.sv
// Execute stage: applies one recipe byte or override to a servo context and forms the result.
// Depends on srs_pkg for the context, configuration, result types and codes.
module srs_exec (
    input  srs_pkg::kind_t kind,
    input  srs_pkg::cmd_t  command,
    input  srs_pkg::ctx_t  ctx,
    input  logic [7:0]     recipe_byte,
    input  srs_pkg::cfg_t  cfg_regs,
    output srs_pkg::ctx_t  ctx_out,
    output srs_pkg::res_t  res
);

    srs_pkg::op_t                op;
    logic [4:0]                  arg;
    logic [4:0]                  span;
    logic [srs_pkg::ADDR_W-1:0]  nxt;
    logic                        upd;
    logic [7:0]                  hold;
    srs_pkg::ctx_t               nc;

    assign op = srs_pkg::op_t'(recipe_byte[7:5]);
    assign arg = recipe_byte[4:0];
    assign span = (ctx.position > arg) ? ctx.position - arg : arg - ctx.position;

    always_comb
    begin
        nc = ctx;
        upd = 1'b0;
        hold = 8'd0;
        nxt = srs_pkg::next_index(ctx.pc);
        case (kind)
            srs_pkg::KIND_STEP:
            begin
                if (ctx.mode == srs_pkg::MODE_RUNNING)
                begin
                    case (op)
                        srs_pkg::OP_MOV:
                        begin
                            nc.position = arg;
                            upd = 1'b1;
                            hold = (8'(span) + 8'd1) * srs_pkg::MOVE_UNITS;
                        end
                        srs_pkg::OP_WAIT:
                        begin
                            hold = 8'(arg) + 8'd1;
                        end
                        srs_pkg::OP_LOOP:
                        begin
                            if (ctx.loop_active)
                            begin
                                nc.mode = srs_pkg::MODE_NESTED;
                            end
                            else
                            begin
                                nc.loop_times = arg;
                                nc.loop_start = ctx.pc;
                                nc.loop_count = 5'd0;
                                nc.loop_active = 1'b1;
                            end
                        end
                        srs_pkg::OP_END_LOOP:
                        begin
                            if (!ctx.loop_active)
                            begin
                                nc.mode = srs_pkg::MODE_NESTED;
                            end
                            else if (ctx.loop_count == ctx.loop_times)
                            begin
                                nc.loop_active = 1'b0;
                            end
                            else
                            begin
                                nc.loop_count = ctx.loop_count + 5'd1;
                                nxt = srs_pkg::next_index(ctx.loop_start);
                            end
                        end
                        srs_pkg::OP_END:
                        begin
                            nc.mode = srs_pkg::MODE_END;
                        end
                        default:
                        begin
                            nc.mode = srs_pkg::MODE_CMD_ERR;
                        end
                    endcase
                    nc.pc = nxt;
                end
            end
            srs_pkg::KIND_OVERRIDE:
            begin
                case (command)
                    srs_pkg::CMD_PAUSE:
                    begin
                        if (ctx.mode inside {srs_pkg::MODE_RUNNING, srs_pkg::MODE_PAUSED})
                        begin
                            nc.mode = srs_pkg::MODE_PAUSED;
                        end
                    end
                    srs_pkg::CMD_CONTINUE:
                    begin
                        if (ctx.mode inside {srs_pkg::MODE_RUNNING, srs_pkg::MODE_PAUSED})
                        begin
                            nc.mode = srs_pkg::MODE_RUNNING;
                        end
                    end
                    srs_pkg::CMD_RIGHT:
                    begin
                        if (ctx.mode == srs_pkg::MODE_PAUSED && ctx.position != 5'd0)
                        begin
                            nc.position = ctx.position - 5'd1;
                            upd = 1'b1;
                            hold = srs_pkg::MANUAL_HOLD;
                        end
                    end
                    srs_pkg::CMD_LEFT:
                    begin
                        if (ctx.mode == srs_pkg::MODE_PAUSED &&
                            ctx.position < cfg_regs.max_position)
                        begin
                            nc.position = ctx.position + 5'd1;
                            upd = 1'b1;
                            hold = srs_pkg::MANUAL_HOLD;
                        end
                    end
                    srs_pkg::CMD_RESTART:
                    begin
                        nc.pc = '0;
                        nc.loop_active = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign ctx_out = nc;
    assign res.pulse_len = 17'(cfg_regs.pulse_base) +
                           17'(nc.position) * 17'(cfg_regs.pulse_step);
    assign res.pulse_update = upd;
    assign res.hold_units = hold;
    assign res.mode = nc.mode;

endmodule

FILE: rtl/core/servo_recipe_sequencer.sv
// Servo recipe sequencer: accepts one item per cycle when consecutive steps or overrides
// address different servos and the result output is not held; a step or override that follows
// one for the same servo waits until the earlier one has written back its servo context, since
// the next item reads that context to address the registered recipe memory read. A result is
// registered in the output register when its item leaves execute. Load items write the
// recipe memory at acceptance, and a recipe byte never loaded since reset reads as zero.
// Depends on srs_pkg, srs_channels, srs_ram and srs_exec.
module servo_recipe_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    srs_item_if.sink            item,
    srs_result_if.source        result,
    srs_cfg_if.sink             cfg
);

    logic [15:0]                   pulse_base_reg;
    logic [10:0]                   pulse_step_reg;
    logic [4:0]                    max_position_reg;
    srs_pkg::cfg_t                 cfg_regs;

    srs_pkg::kind_t                in_kind;
    logic [srs_pkg::SERVO_W-1:0]   in_servo;
    logic                          item_take;
    logic [srs_pkg::ADDR_W-1:0]    load_addr_w;
    logic [srs_pkg::ADDR_W-1:0]    read_addr;
    logic                          ram_we;
    logic [7:0]                    ram_rdata;
    logic [srs_pkg::RECIPE_DEPTH-1:0] loaded_reg;
    logic                          loaded_rd_reg;
    logic [7:0]                    recipe_byte;

    srs_pkg::ctx_t                 ctx_reg [srs_pkg::SERVO_COUNT];
    srs_pkg::ctx_t                 ctx_next;

    logic                          s2_valid_reg;
    srs_pkg::kind_t                s2_kind_reg;
    logic [srs_pkg::SERVO_W-1:0]   s2_servo_reg;
    srs_pkg::cmd_t                 s2_cmd_reg;
    logic                          s2_adv;
    logic                          s2_hazard;

    logic                          out_valid_reg;
    srs_pkg::res_t                 out_res_reg;
    srs_pkg::res_t                 res_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_base_reg <= 16'd0;
            pulse_step_reg <= 11'd0;
            max_position_reg <= srs_pkg::MAX_POSITION_RESET;
        end
        else if (cfg.valid)
        begin
            case (srs_pkg::cfg_index_t'(cfg.index))
                srs_pkg::CFG_PULSE_BASE:   pulse_base_reg <= cfg.data;
                srs_pkg::CFG_PULSE_STEP:   pulse_step_reg <= cfg.data[10:0];
                srs_pkg::CFG_MAX_POSITION: max_position_reg <= cfg.data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_regs = '{
        pulse_base:   pulse_base_reg,
        pulse_step:   pulse_step_reg,
        max_position: max_position_reg
    };

    assign in_kind = srs_pkg::kind_t'(item.kind);
    assign in_servo = (srs_pkg::SERVO_COUNT == 1) ? '0 : srs_pkg::SERVO_W'(item.servo_id);
    assign load_addr_w = srs_pkg::wrap_addr(item.load_addr);
    assign read_addr = ctx_reg[in_servo].pc;

    // A step or override still in execute for the same servo has not written its context back.
    assign s2_hazard = s2_valid_reg && (s2_servo_reg == in_servo) &&
                       (s2_kind_reg == srs_pkg::KIND_STEP ||
                        s2_kind_reg == srs_pkg::KIND_OVERRIDE);
    assign s2_adv = s2_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = (!s2_valid_reg || s2_adv) && !s2_hazard;
    assign item_take = item.valid && item.ready;
    assign ram_we = item_take && (in_kind == srs_pkg::KIND_LOAD);

    srs_ram #(
        .WIDTH (8),
        .DEPTH (srs_pkg::RECIPE_DEPTH)
    ) u_recipe_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_addr_w),
        .wdata (item.load_byte),
        .re    (item_take),
        .raddr (read_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            loaded_rd_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                loaded_reg[load_addr_w] <= 1'b1;
            end
            if (item_take)
            begin
                loaded_rd_reg <= loaded_reg[read_addr];
            end
        end
    end

    assign recipe_byte = loaded_rd_reg ? ram_rdata : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s2_kind_reg <= in_kind;
            s2_servo_reg <= in_servo;
            s2_cmd_reg <= srs_pkg::cmd_t'(item.command);
        end
    end

    srs_exec u_exec (
        .kind        (s2_kind_reg),
        .command     (s2_cmd_reg),
        .ctx         (ctx_reg[s2_servo_reg]),
        .recipe_byte (recipe_byte),
        .cfg_regs    (cfg_regs),
        .ctx_out     (ctx_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < srs_pkg::SERVO_COUNT; i++)
            begin
                ctx_reg[i] <= srs_pkg::CTX_RESET;
            end
        end
        else if (s2_adv)
        begin
            ctx_reg[s2_servo_reg] <= ctx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.pulse_len = out_res_reg.pulse_len;
    assign result.pulse_update = out_res_reg.pulse_update;
    assign result.hold_units = out_res_reg.hold_units;
    assign result.mode = out_res_reg.mode;

endmodule
